/* rtl/cht_pkg.sv */
`default_nettype none
package cht_pkg;
	localparam int TABLE_ROWS_DEF   = 64;
	localparam int NUM_SUBJECTS_DEF = 16;
	localparam int GEN_BITS_DEF     = 14;

	typedef enum logic [3:0] {
		CMD_GRANT     = 4'd0,
		CMD_REVOKE    = 4'd1,
		CMD_CHECK     = 4'd2,
		CMD_GRANT_H   = 4'd3,
		CMD_CHECK_H   = 4'd4,
		CMD_REVOKE_H  = 4'd5,
		CMD_REVOKE_OW = 4'd6,
		CMD_LIVE_CNT  = 4'd7,
		CMD_CLEAR     = 4'd8
	} cmd_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SUBJ = 2'd1;
	localparam logic [1:0] ST_CAP  = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	localparam logic [1:0] REG_CAP_MIN = 2'd0;
	localparam logic [1:0] REG_CAP_MAX = 2'd1;
	localparam logic [1:0] REG_TAG     = 2'd2;

	// classified command handed from front to back
	typedef struct packed {
		logic [3:0]  command;
		logic        pre_fail;
		logic [1:0]  pre_status;
		logic        subj_ok;
		logic [7:0]  owner_sid;
		logic [7:0]  cap_id;
		logic [15:0] handle_slot;
		logic [15:0] handle_generation;
	} job_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        handle_valid;
		logic [5:0]  out_slot;
		logic [13:0] out_generation;
		logic [7:0]  out_tag;
		logic [6:0]  row_count;
	} res_t;
endpackage
`default_nettype wire

/* rtl/cht_if.sv */
`default_nettype none
interface cht_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [7:0]  owner_sid;
	logic [7:0]  grantor_sid;
	logic [7:0]  cap_id;
	logic [15:0] handle_slot;
	logic [13:0] handle_generation;
	logic [7:0]  handle_tag;
	modport source (output valid, command, owner_sid, grantor_sid, cap_id,
		handle_slot, handle_generation, handle_tag, input ready);
	modport sink (input valid, command, owner_sid, grantor_sid, cap_id,
		handle_slot, handle_generation, handle_tag, output ready);
endinterface

interface cht_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        handle_valid;
	logic [5:0]  out_slot;
	logic [13:0] out_generation;
	logic [7:0]  out_tag;
	logic [6:0]  row_count;
	modport source (output valid, status, handle_valid, out_slot, out_generation,
		out_tag, row_count, input ready);
	modport sink (input valid, status, handle_valid, out_slot, out_generation,
		out_tag, row_count, output ready);
endinterface

interface cht_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/capability_handle_table_core.sv */
// flow: rejected, clear and bad-owner revoke commands go straight to the result;
// handle check/revoke read the row, then execute; owner revoke and live count walk
// every row; grant, revoke and check search every row (one row read a cycle), then
// pick, read and execute. The back end runs one command at a time and waits out
// result stalls; the two-entry queue takes new commands while the back end works
// reset: asynchronous, empties the table and restores the registers to their defaults
`default_nettype none
module capability_handle_table_core
	import cht_pkg::*;
#(
	parameter int TABLE_ROWS   = TABLE_ROWS_DEF,
	parameter int NUM_SUBJECTS = NUM_SUBJECTS_DEF,
	parameter int GEN_BITS     = GEN_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	cht_cmd_if.sink  cmd,
	cht_res_if.source rsp,
	cht_cfg_if.sink  cfg
);
	logic [7:0] cap_min_q, cap_max_q, ktag_q;
	job_t jin, jout;
	logic qfull, qne, qpop, busy;
	res_t r;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !qfull;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_min_q <= 8'd1; cap_max_q <= 8'd8; ktag_q <= 8'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CAP_MIN: cap_min_q <= cfg.data;
				REG_CAP_MAX: cap_max_q <= cfg.data;
				REG_TAG:     ktag_q <= cfg.data;
				default: ;
			endcase
		end
	end

	cht_front #(.NUM_SUBJECTS(NUM_SUBJECTS)) u_front (
		.cap_min(cap_min_q), .cap_max(cap_max_q), .ktag(ktag_q),
		.command(cmd.command), .owner_sid(cmd.owner_sid),
		.grantor_sid(cmd.grantor_sid), .cap_id(cmd.cap_id),
		.handle_slot(cmd.handle_slot), .handle_generation(cmd.handle_generation),
		.handle_tag(cmd.handle_tag), .job(jin));

	cht_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(cmd.valid && !qfull), .din(jin),
		.full(qfull), .pop(qpop), .nonempty(qne), .dout(jout));

	cht_back #(.TABLE_ROWS(TABLE_ROWS), .GEN_BITS(GEN_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .ktag(ktag_q), .job_valid(qne), .job(jout),
		.job_pop(qpop), .res_valid(rsp.valid), .res_ready(rsp.ready), .res(r),
		.busy(busy));

	assign rsp.status = r.status;
	assign rsp.handle_valid = r.handle_valid;
	assign rsp.out_slot = r.out_slot;
	assign rsp.out_generation = r.out_generation;
	assign rsp.out_tag = r.out_tag;
	assign rsp.row_count = r.row_count;

	// a pop only happens when the back end is idle
	assert property (@(posedge clk) disable iff (!arst_n) qpop |-> !busy)
		else $error("pop while busy");
	// a null handle carries zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.handle_valid) |-> (rsp.out_tag == 8'd0))
		else $error("null handle with tag");
	// a result follows only from a popped command
	assert property (@(posedge clk) disable iff (!arst_n) $rose(rsp.valid) |-> busy)
		else $error("result without command");
endmodule
`default_nettype wire

/* rtl/cht_front.sv */
`default_nettype none
module cht_front
	import cht_pkg::*;
#(
	parameter int NUM_SUBJECTS = NUM_SUBJECTS_DEF
) (
	input  wire logic [7:0]  cap_min,
	input  wire logic [7:0]  cap_max,
	input  wire logic [7:0]  ktag,
	input  wire logic [3:0]  command,
	input  wire logic [7:0]  owner_sid,
	input  wire logic [7:0]  grantor_sid,
	input  wire logic [7:0]  cap_id,
	input  wire logic [15:0] handle_slot,
	input  wire logic [13:0] handle_generation,
	input  wire logic [7:0]  handle_tag,
	output job_t             job
);
	logic own_ok, gra_ok, cap_ok;

	// validity checks: subjects first, then the id range; handle commands check the tag first
	always_comb begin
		own_ok = {1'b0, owner_sid} < 9'(NUM_SUBJECTS);
		gra_ok = {1'b0, grantor_sid} < 9'(NUM_SUBJECTS);
		cap_ok = (cap_id >= cap_min) && (cap_id <= cap_max);
		job = '0;
		job.command = command;
		job.subj_ok = own_ok;
		job.owner_sid = owner_sid;
		job.cap_id = cap_id;
		job.handle_slot = handle_slot;
		job.handle_generation = {2'b00, handle_generation};
		job.pre_status = ST_OK;
		job.pre_fail = 1'b0;
		unique case (command)
			CMD_GRANT: begin
				if (!own_ok || !gra_ok) begin
					job.pre_fail = 1'b1; job.pre_status = ST_SUBJ;
				end else if (!cap_ok) begin
					job.pre_fail = 1'b1; job.pre_status = ST_CAP;
				end
			end
			CMD_REVOKE, CMD_CHECK, CMD_GRANT_H: begin
				if (!own_ok) begin
					job.pre_fail = 1'b1; job.pre_status = ST_SUBJ;
				end else if (!cap_ok) begin
					job.pre_fail = 1'b1; job.pre_status = ST_CAP;
				end
			end
			CMD_CHECK_H, CMD_REVOKE_H: begin
				if (handle_tag != ktag) begin
					job.pre_fail = 1'b1; job.pre_status = ST_CAP;
				end else if (command == CMD_CHECK_H && !cap_ok) begin
					job.pre_fail = 1'b1; job.pre_status = ST_CAP;
				end
			end
			CMD_REVOKE_OW, CMD_LIVE_CNT, CMD_CLEAR: ;
			default: begin
				job.pre_fail = 1'b1; job.pre_status = ST_CAP;
			end
		endcase
	end
endmodule
`default_nettype wire

/* rtl/cht_queue.sv */
`default_nettype none
module cht_queue
	import cht_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t din,
	output logic      full,
	input  wire logic pop,
	output logic      nonempty,
	output job_t      dout
);
	job_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign dout = ent_q[rp_q];

	// two-entry fifo
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= din;
	end
endmodule
`default_nettype wire

/* rtl/cht_back.sv */
`default_nettype none
module cht_back
	import cht_pkg::*;
#(
	parameter int TABLE_ROWS = TABLE_ROWS_DEF,
	parameter int GEN_BITS   = GEN_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [7:0] ktag,
	input  wire logic job_valid,
	input  wire job_t job,
	output logic      job_pop,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res,
	output logic      busy
);
	localparam int RW = $clog2(TABLE_ROWS);
	localparam int CW = $clog2(TABLE_ROWS + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PICK, S_RD, S_EXEC, S_WALK, S_OUT} st_t;

	// row store: flags in flops, payload in a memory
	logic [TABLE_ROWS-1:0] live_q, rev_q, used_q;
	logic [7:0]            capm [TABLE_ROWS];
	logic [7:0]            ownm [TABLE_ROWS];
	logic [GEN_BITS-1:0]   genm [TABLE_ROWS];

	st_t             st_q;
	job_t            job_q;
	logic [RW:0]     idx_q;
	logic            hit_q, fnew_q, frev_q;
	logic [RW-1:0]   hit_row_q, new_row_q, rev_row_q, row_q;
	logic [CW-1:0]   cnt_q;
	logic [7:0]      rd_cap_q, rd_own_q;
	logic [GEN_BITS-1:0] rd_gen_q;
	res_t            res_q;
	logic [RW-1:0]   ix;
	logic            slot_ok;
	logic            hcmd;

	assign ix = idx_q[RW-1:0];
	assign job_pop = (st_q == S_IDLE) && job_valid;
	assign res_valid = st_q == S_OUT;
	assign res = res_q;
	assign busy = st_q != S_IDLE;
	assign slot_ok = job_q.handle_slot < 16'(TABLE_ROWS);
	assign hcmd = (job_q.command == CMD_CHECK_H) || (job_q.command == CMD_REVOKE_H);

	// registered row read
	always_ff @(posedge clk) begin
		rd_cap_q <= capm[ix];
		rd_own_q <= ownm[ix];
		rd_gen_q <= genm[ix];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			live_q <= '0; rev_q <= '0; used_q <= '0;
			idx_q <= '0; res_q <= '0; job_q <= '0;
			hit_q <= 1'b0; fnew_q <= 1'b0; frev_q <= 1'b0; cnt_q <= '0;
			hit_row_q <= '0; new_row_q <= '0; rev_row_q <= '0; row_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (job_valid) begin
					job_q <= job;
					res_q <= '{status: job.pre_status, default: '0};
					idx_q <= (job.command == CMD_CHECK_H || job.command == CMD_REVOKE_H) ?
						job.handle_slot[RW:0] : '0;
					cnt_q <= '0;
					hit_q <= 1'b0; fnew_q <= 1'b0; frev_q <= 1'b0;
					if (job.pre_fail) st_q <= S_OUT;
					else if (job.command == CMD_CLEAR) begin
						live_q <= '0; rev_q <= '0; used_q <= '0; st_q <= S_OUT;
					end else if (job.command == CMD_LIVE_CNT) st_q <= S_WALK;
					else if (job.command == CMD_REVOKE_OW) begin
						st_q <= job.subj_ok ? S_WALK : S_OUT;
					end else if (job.command == CMD_CHECK_H ||
							job.command == CMD_REVOKE_H) begin
						st_q <= S_RD;
					end else st_q <= S_SCAN;
				end
				// address one row; data lands for the next cycle
				S_RD: begin
					if (hcmd && !slot_ok) begin
						res_q.status <= ST_CAP; st_q <= S_OUT;
					end else begin
						if (hcmd) row_q <= job_q.handle_slot[RW-1:0];
						st_q <= S_EXEC;
					end
				end
				// pipelined scan: compare row idx-1 while addressing idx
				S_SCAN: begin
					if (idx_q != '0) begin
						if (live_q[ix-RW'(1)] && used_q[ix-RW'(1)] &&
							rd_own_q == job_q.owner_sid &&
							rd_cap_q == job_q.cap_id && !hit_q) begin
							hit_q <= 1'b1; hit_row_q <= ix - RW'(1);
						end
					end
					if (idx_q < (RW+1)'(TABLE_ROWS)) begin
						if (!live_q[ix] && !rev_q[ix] && !fnew_q) begin
							fnew_q <= 1'b1; new_row_q <= ix;
						end
						if (!live_q[ix] && !frev_q) begin
							frev_q <= 1'b1; rev_row_q <= ix;
						end
						idx_q <= idx_q + 1'b1;
					end else st_q <= S_PICK;
				end
				// choose the target row once the last compare has landed
				S_PICK: begin
					row_q <= hit_q ? hit_row_q : (fnew_q ? new_row_q : rev_row_q);
					idx_q <= {1'b0, hit_q ? hit_row_q :
						(fnew_q ? new_row_q : rev_row_q)};
					st_q <= S_RD;
				end
				S_EXEC: begin
					st_q <= S_OUT;
					unique case (job_q.command)
						CMD_GRANT, CMD_GRANT_H: begin
							if (hit_q) begin
								if (job_q.command == CMD_GRANT_H) begin
									res_q.handle_valid <= 1'b1;
									res_q.out_slot <= 6'(row_q);
									res_q.out_generation <= 14'(rd_gen_q);
									res_q.out_tag <= ktag;
								end
							end else if (fnew_q || frev_q) begin
								live_q[row_q] <= 1'b1; rev_q[row_q] <= 1'b0;
								used_q[row_q] <= 1'b1;
								if (job_q.command == CMD_GRANT_H) begin
									res_q.handle_valid <= 1'b1;
									res_q.out_slot <= 6'(row_q);
									res_q.out_generation <= 14'(used_q[row_q] ?
										rd_gen_q + 1'b1 : GEN_BITS'(1));
									res_q.out_tag <= ktag;
								end
							end else res_q.status <= ST_CAP;
						end
						CMD_REVOKE, CMD_CHECK: begin
							if (!hit_q) res_q.status <= ST_MISS;
							else if (job_q.command == CMD_REVOKE) begin
								live_q[row_q] <= 1'b0; rev_q[row_q] <= 1'b1;
							end
						end
						default: begin
							if (!live_q[row_q]) res_q.status <= ST_MISS;
							else if (rd_gen_q != job_q.handle_generation[GEN_BITS-1:0])
								res_q.status <= ST_MISS;
							else if (job_q.command == CMD_CHECK_H) begin
								if (rd_cap_q != job_q.cap_id) res_q.status <= ST_CAP;
							end else begin
								live_q[row_q] <= 1'b0; rev_q[row_q] <= 1'b1;
							end
						end
					endcase
				end
				// one row a cycle for owner revoke and live count
				S_WALK: begin
					if (idx_q == (RW+1)'(TABLE_ROWS + 1)) begin
						res_q.row_count <= 7'(cnt_q); st_q <= S_OUT;
					end else begin
						if (idx_q != '0 && live_q[ix-RW'(1)]) begin
							if (job_q.command == CMD_LIVE_CNT) cnt_q <= cnt_q + 1'b1;
							else if (rd_own_q == job_q.owner_sid) begin
								cnt_q <= cnt_q + 1'b1;
								live_q[ix-RW'(1)] <= 1'b0; rev_q[ix-RW'(1)] <= 1'b1;
							end
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_OUT: if (res_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// memory writes: grant fills, revokes bump the generation
	always_ff @(posedge clk) begin
		if (st_q == S_EXEC) begin
			if ((job_q.command == CMD_GRANT || job_q.command == CMD_GRANT_H)
					&& !hit_q && (fnew_q || frev_q)) begin
				capm[row_q] <= job_q.cap_id;
				ownm[row_q] <= job_q.owner_sid;
				genm[row_q] <= used_q[row_q] ? rd_gen_q + 1'b1 : GEN_BITS'(1);
			end else if ((job_q.command == CMD_REVOKE && hit_q) ||
					(job_q.command == CMD_REVOKE_H && live_q[row_q] &&
					rd_gen_q == job_q.handle_generation[GEN_BITS-1:0])) begin
				genm[row_q] <= rd_gen_q + 1'b1;
			end
		end else if (st_q == S_WALK && job_q.command == CMD_REVOKE_OW &&
				idx_q != '0 && idx_q != (RW+1)'(TABLE_ROWS + 1) &&
				live_q[ix-RW'(1)] && rd_own_q == job_q.owner_sid) begin
			genm[ix-RW'(1)] <= rd_gen_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

/* tb/tb_capability_handle_table_core.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_capability_handle_table_core;
	import cht_pkg::*;

	localparam int ROWS = TABLE_ROWS_DEF;
	localparam int SUBJECTS = NUM_SUBJECTS_DEF;
	localparam int CYCLE_LIMIT = 900000;

	logic clk;
	logic arst_n;

	cht_cmd_if cmd_ch ();
	cht_res_if rsp_ch ();
	cht_cfg_if cfg_ch ();

	capability_handle_table_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.rsp(rsp_ch.source),
		.cfg(cfg_ch.sink)
	);

	// shadow copy of the table and registers
	logic        row_live [ROWS];
	logic        row_revoked [ROWS];
	logic [7:0]  row_cap [ROWS];
	logic [7:0]  row_own [ROWS];
	logic [13:0] row_gen [ROWS];
	logic [7:0]  id_min;
	logic [7:0]  id_max;
	logic [7:0]  tag_reg;

	res_t expected_results [$];
	int   error_count = 0;
	int   cycle_count = 0;
	int   burst_left;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic bit subject_valid(logic [7:0] s);
		return s < SUBJECTS;
	endfunction

	function automatic bit cap_valid(logic [7:0] c);
		return c >= id_min && c <= id_max;
	endfunction

	function automatic int live_row_of(logic [7:0] o, logic [7:0] c);
		for (int i = 0; i < ROWS; i++)
			if (row_live[i] && row_own[i] == o && row_cap[i] == c) return i;
		return -1;
	endfunction

	function automatic int free_row();
		for (int i = 0; i < ROWS; i++)
			if (!row_live[i] && !row_revoked[i]) return i;
		for (int i = 0; i < ROWS; i++)
			if (!row_live[i]) return i;
		return -1;
	endfunction

	function automatic void occupy_row(int r, logic [7:0] o, logic [7:0] c);
		row_cap[r] = c;
		row_own[r] = o;
		row_gen[r] = row_gen[r] + 14'd1;
		row_live[r] = 1'b1;
		row_revoked[r] = 1'b0;
	endfunction

	function automatic void retire_row(int r);
		row_live[r] = 1'b0;
		row_revoked[r] = 1'b1;
		row_gen[r] = row_gen[r] + 14'd1;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < ROWS; i++) begin
			row_live[i] = 0; row_revoked[i] = 0; row_cap[i] = 0;
			row_own[i] = 0; row_gen[i] = 0;
		end
	endfunction

	// table behavior for one command
	function automatic res_t table_outcome(logic [3:0] op, logic [7:0] o, logic [7:0] g,
			logic [7:0] c, logic [15:0] hs, logic [13:0] hg, logic [7:0] ht);
		res_t res;
		int r;
		res = '0;
		res.status = ST_OK;
		case (op)
			CMD_GRANT: begin
				if (!subject_valid(o) || !subject_valid(g)) res.status = ST_SUBJ;
				else if (!cap_valid(c)) res.status = ST_CAP;
				else if (live_row_of(o, c) < 0) begin
					r = free_row();
					if (r < 0) res.status = ST_CAP;
					else occupy_row(r, o, c);
				end
			end
			CMD_REVOKE, CMD_CHECK: begin
				if (!subject_valid(o)) res.status = ST_SUBJ;
				else if (!cap_valid(c)) res.status = ST_CAP;
				else begin
					r = live_row_of(o, c);
					if (r < 0) res.status = ST_MISS;
					else if (op == CMD_REVOKE) retire_row(r);
				end
			end
			CMD_GRANT_H: begin
				if (!subject_valid(o)) res.status = ST_SUBJ;
				else if (!cap_valid(c)) res.status = ST_CAP;
				else begin
					r = live_row_of(o, c);
					if (r < 0) begin
						r = free_row();
						if (r >= 0) occupy_row(r, o, c);
					end
					if (r < 0) res.status = ST_CAP;
					else begin
						res.handle_valid = 1'b1;
						res.out_slot = r[5:0];
						res.out_generation = row_gen[r];
						res.out_tag = tag_reg;
					end
				end
			end
			CMD_CHECK_H, CMD_REVOKE_H: begin
				if (ht != tag_reg) res.status = ST_CAP;
				else if (op == CMD_CHECK_H && !cap_valid(c)) res.status = ST_CAP;
				else if (hs >= ROWS) res.status = ST_CAP;
				else if (!row_live[hs]) res.status = ST_MISS;
				else if (row_gen[hs] != hg) res.status = ST_MISS;
				else if (op == CMD_CHECK_H) begin
					if (row_cap[hs] != c) res.status = ST_CAP;
				end else retire_row(hs);
			end
			CMD_REVOKE_OW: begin
				if (subject_valid(o))
					for (int i = 0; i < ROWS; i++)
						if (row_live[i] && row_own[i] == o) begin
							retire_row(i);
							res.row_count++;
						end
			end
			CMD_LIVE_CNT: begin
				for (int i = 0; i < ROWS; i++)
					if (row_live[i]) res.row_count++;
			end
			CMD_CLEAR: wipe_table();
			default: res.status = ST_CAP;
		endcase
		return res;
	endfunction

	// send one command beat, with bursty gaps
	task automatic send_command(logic [3:0] op, logic [7:0] o, logic [7:0] g, logic [7:0] c,
			logic [15:0] hs, logic [13:0] hg, logic [7:0] ht);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 80)) @(posedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.owner_sid <= o;
		cmd_ch.grantor_sid <= g;
		cmd_ch.cap_id <= c;
		cmd_ch.handle_slot <= hs;
		cmd_ch.handle_generation <= hg;
		cmd_ch.handle_tag <= ht;
		do @(posedge clk); while (!cmd_ch.ready);
		expected_results.push_back(table_outcome(op, o, g, c, hs, hg, ht));
	endtask

	task automatic go_idle();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (ROWS + 10) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [7:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CAP_MIN: id_min = val;
			REG_CAP_MAX: id_max = val;
			default: tag_reg = val;
		endcase
	endtask

	// receiver stall pattern and result check
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) rsp_ch.ready <= 1'b0;
		else begin
			rsp_ch.ready <= (cycle_count % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.status !== want.status) begin
						$error("status exp %0d got %0d", want.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.handle_valid !== want.handle_valid) begin
						$error("handle_valid exp %0d got %0d", want.handle_valid,
							rsp_ch.handle_valid);
						error_count++;
					end
					if (rsp_ch.out_slot !== want.out_slot) begin
						$error("out_slot exp %0d got %0d", want.out_slot, rsp_ch.out_slot);
						error_count++;
					end
					if (rsp_ch.out_generation !== want.out_generation) begin
						$error("out_generation exp %0d got %0d", want.out_generation,
							rsp_ch.out_generation);
						error_count++;
					end
					if (rsp_ch.out_tag !== want.out_tag) begin
						$error("out_tag exp %0d got %0d", want.out_tag, rsp_ch.out_tag);
						error_count++;
					end
					if (rsp_ch.row_count !== want.row_count) begin
						$error("row_count exp %0d got %0d", want.row_count, rsp_ch.row_count);
						error_count++;
					end
				end
			end
		end
	end

	// directed: extremes, every command and the special cases
	task automatic test_directed();
		send_command(CMD_GRANT, 8'd3, 8'd4, 8'd2, 0, 0, 0);
		send_command(CMD_GRANT, 8'd3, 8'd4, 8'd2, 0, 0, 0);
		send_command(CMD_GRANT, 8'd255, 8'd0, 8'd2, 0, 0, 0);
		send_command(CMD_GRANT, 8'd0, 8'd16, 8'd255, 0, 0, 0);
		send_command(CMD_GRANT, 8'd0, 8'd15, 8'd0, 0, 0, 0);
		send_command(CMD_CHECK, 8'd3, 8'd0, 8'd2, 0, 0, 0);
		send_command(CMD_CHECK, 8'd3, 8'd0, 8'd8, 0, 0, 0);
		send_command(CMD_GRANT_H, 8'd15, 8'd0, 8'd8, 0, 0, 0);
		send_command(CMD_GRANT_H, 8'd16, 8'd0, 8'd8, 0, 0, 0);
		send_command(CMD_CHECK_H, 0, 0, 8'd8, 16'd1, 14'd1, 8'd1);
		send_command(CMD_CHECK_H, 0, 0, 8'd7, 16'd1, 14'd1, 8'd1);
		send_command(CMD_CHECK_H, 0, 0, 8'd8, 16'd1, 14'd1, 8'd0);
		send_command(CMD_CHECK_H, 0, 0, 8'd9, 16'd1, 14'd1, 8'd1);
		send_command(CMD_CHECK_H, 0, 0, 8'd8, 16'hFFFF, 14'h3FFF, 8'd1);
		send_command(CMD_CHECK_H, 0, 0, 8'd8, 16'd1, 14'h3FFF, 8'd1);
		send_command(CMD_CHECK_H, 0, 0, 8'd8, 16'd63, 14'd0, 8'd1);
		send_command(CMD_REVOKE_H, 0, 0, 0, 16'd1, 14'd1, 8'd1);
		send_command(CMD_REVOKE_H, 0, 0, 0, 16'd1, 14'd1, 8'd1);
		send_command(CMD_REVOKE, 8'd3, 0, 8'd2, 0, 0, 0);
		send_command(CMD_GRANT, 8'd5, 8'd5, 8'd1, 0, 0, 0);
		send_command(CMD_REVOKE_OW, 8'd5, 0, 0, 0, 0, 0);
		send_command(CMD_REVOKE_OW, 8'd200, 0, 0, 0, 0, 0);
		send_command(CMD_LIVE_CNT, 0, 0, 0, 0, 0, 0);
		send_command(4'd15, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 14'h3FFF, 8'hFF);
		send_command(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		go_idle();
	endtask

	// fill the table past its size, then revoke every third owner and grant again
	task automatic test_table_full();
		for (int i = 0; i < ROWS + 4; i++)
			send_command(($urandom_range(0, 1) != 0) ? CMD_GRANT : CMD_GRANT_H,
				8'(i % SUBJECTS), 8'd1, 8'(1 + i / SUBJECTS), 0, 0, 0);
		send_command(CMD_LIVE_CNT, 0, 0, 0, 0, 0, 0);
		for (int s = 0; s < SUBJECTS; s += 3)
			send_command(CMD_REVOKE_OW, 8'(s), 0, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			send_command(CMD_GRANT_H, 8'd7, 0, 8'd6 + i[0], 0, 0, 0);
		send_command(CMD_LIVE_CNT, 0, 0, 0, 0, 0, 0);
		go_idle();
	endtask

	// random, mostly well-formed handle traffic under one register setting
	task automatic test_random(int count, logic [7:0] lo, logic [7:0] hi, logic [7:0] tg);
		logic [3:0] op;
		logic [7:0] o, c;
		logic [15:0] hs;
		logic [13:0] hg;
		logic [7:0] ht;
		int sel;
		write_register(REG_CAP_MIN, lo);
		write_register(REG_CAP_MAX, hi);
		write_register(REG_TAG, tg);
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			o = (sel < 90) ? 8'($urandom_range(0, SUBJECTS - 1)) : 8'($urandom_range(0, 255));
			c = (sel < 85 && lo <= hi) ? 8'($urandom_range(lo, hi)) :
				8'($urandom_range(0, 255));
			hs = 16'($urandom_range(0, ROWS - 1));
			hg = row_gen[hs];
			ht = tg;
			if (sel >= 90) begin
				hs = 16'($urandom_range(0, 65535));
				hg = 14'($urandom_range(0, 16383));
				ht = 8'($urandom_range(0, 255));
			end else if (sel >= 80) hg = 14'(hg + $urandom_range(1, 3));
			else if (sel < 50 && row_live[hs]) c = row_cap[hs];
			sel = $urandom_range(0, 99);
			if (sel < 25) op = CMD_GRANT;
			else if (sel < 45) op = CMD_GRANT_H;
			else if (sel < 55) op = CMD_CHECK;
			else if (sel < 62) op = CMD_REVOKE;
			else if (sel < 77) op = CMD_CHECK_H;
			else if (sel < 87) op = CMD_REVOKE_H;
			else if (sel < 92) op = CMD_REVOKE_OW;
			else if (sel < 96) op = CMD_LIVE_CNT;
			else if (sel < 97) op = CMD_CLEAR;
			else op = 4'($urandom_range(9, 15));
			send_command(op, o, ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15)) :
				8'($urandom_range(0, 255)), c, hs, hg, ht);
		end
		go_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		burst_left = 0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_GRANT;
		cmd_ch.owner_sid = '0;
		cmd_ch.grantor_sid = '0;
		cmd_ch.cap_id = '0;
		cmd_ch.handle_slot = '0;
		cmd_ch.handle_generation = '0;
		cmd_ch.handle_tag = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_CAP_MIN;
		cfg_ch.data = '0;
		id_min = 8'd1;
		id_max = 8'd8;
		tag_reg = 8'd1;
		wipe_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_random(120, 8'd1, 8'd8, 8'd1);
		test_random(100, 8'd0, 8'd3, 8'd255);
		test_random(60, 8'd252, 8'd255, 8'd0);
		test_random(30, 8'd9, 8'd4, 8'd170);
		test_random(40, 8'd0, 8'd255, 8'd85);

		if (error_count == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
